FILE: design/cbc_pkg.sv
// Shared types, constants and rounding helper for the circle/box collision pipeline.
package cbc_pkg;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned Q14_ONE    = 16384;

  // Geometry traveling alongside the sine unit.
  typedef struct packed {
    logic               valid;
    logic               geo;
    logic               cb;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        r;
    logic [30:0]        hx;
    logic [30:0]        hy;
  } sn_side_t;

  // Contact data traveling alongside the square root unit.
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        sx;
    logic        sy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] r;
  } sq_side_t;

  // Result data traveling alongside the divider.
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        nz;
    logic        sx;
    logic        sy;
    logic [30:0] depth;
  } dv_side_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        depth;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } res_t;

  // Divide by 2^14, magnitude rounded to nearest, halves away from zero.
  function automatic logic signed [37:0] round_q14(input logic signed [50:0] v);
    logic [50:0] m;
    logic [50:0] r;
    m = v[50] ? 51'(-v) : 51'(v);
    r = (m + 51'd8192) >> 14;
    return v[50] ? -$signed({1'b0, r[36:0]}) : $signed({1'b0, r[36:0]});
  endfunction

endpackage

FILE: design/cbc_sine.sv
// Four-stage sine and cosine polynomial unit with geometry passed alongside.
module cbc_sine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [15:0]       ang_i,
  input  cbc_pkg::sn_side_t side_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o,
  output cbc_pkg::sn_side_t side_o
);
  import cbc_pkg::*;

  logic [15:0] ang_l [2];
  logic [1:0]  q1_d [2];
  logic [14:0] u1_d [2];
  logic [29:0] uu    [2];
  logic [1:0]  q1_q [2], q2_q [2], q3_q [2];
  logic [14:0] u1_q [2], u2_q [2], u3_q [2];
  logic [14:0] x1_q [2], x2_q [2];
  logic [25:0] m1    [2];
  logic [13:0] p2_q [2];
  logic [28:0] m2    [2];
  logic [14:0] p3_q [2];
  logic [29:0] m3    [2];
  logic [15:0] s4    [2];
  logic signed [15:0] s4_q [2];
  sn_side_t    side_q [4];

  assign ang_l[0] = ang_i;
  assign ang_l[1] = ang_i + 16'd16384;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q1_d[l] = ang_l[l][15:14];
      u1_d[l] = ang_l[l][14] ? 15'(15'd16384 - {1'b0, ang_l[l][13:0]})
                             : {1'b0, ang_l[l][13:0]};
      uu[l]   = u1_d[l] * u1_d[l];
      m1[l]   = x1_q[l] * 11'd1160;
      m2[l]   = x2_q[l] * p2_q[l];
      m3[l]   = u3_q[l] * p3_q[l];
      s4[l]   = (m3[l][29:14] > 16'(Q14_ONE)) ? 16'(Q14_ONE) : m3[l][29:14];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) side_q[k] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < 4; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        q1_q[l] <= q1_d[l];
        u1_q[l] <= u1_d[l];
        x1_q[l] <= uu[l][28:14];
        q2_q[l] <= q1_q[l];
        u2_q[l] <= u1_q[l];
        x2_q[l] <= x1_q[l];
        p2_q[l] <= 14'd10512 - 14'(m1[l][25:14]);
        q3_q[l] <= q2_q[l];
        u3_q[l] <= u2_q[l];
        p3_q[l] <= 15'd25736 - 15'(m2[l][28:14]);
        s4_q[l] <= q3_q[l][1] ? -$signed(s4[l]) : $signed(s4[l]);
      end
    end
  end

  assign sin_o  = s4_q[0];
  assign cos_o  = s4_q[1];
  assign side_o = side_q[3];

endmodule

FILE: design/cbc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module cbc_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [63:0]       val_i,
  input  cbc_pkg::sq_side_t side_i,
  output logic [31:0]       root_o,
  output cbc_pkg::sq_side_t side_o
);
  import cbc_pkg::*;

  logic [63:0] rem_q  [SQRT_STEPS];
  logic [63:0] res_q  [SQRT_STEPS];
  sq_side_t    side_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] Bit = 64'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    sq_side_t    side_in;

    if (k == 0) begin : g_first
      assign rem_in  = val_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + Bit;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root_o = res_q[SQRT_STEPS-1][31:0];
  assign side_o = side_q[SQRT_STEPS-1];

endmodule

FILE: design/cbc_div.sv
// Pipelined two-lane restoring divider for the normal components.
module cbc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [46:0]       num_x_i,
  input  logic [46:0]       num_y_i,
  input  logic [31:0]       den_i,
  input  cbc_pkg::dv_side_t side_i,
  output logic [14:0]       quo_x_o,
  output logic [14:0]       quo_y_o,
  output cbc_pkg::dv_side_t side_o
);
  import cbc_pkg::*;

  logic [46:0] rx_q  [DIV_STEPS];
  logic [46:0] ry_q  [DIV_STEPS];
  logic [14:0] qx_q  [DIV_STEPS];
  logic [14:0] qy_q  [DIV_STEPS];
  logic [31:0] d_q   [DIV_STEPS];
  dv_side_t    side_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int unsigned Sh = DIV_STEPS - 1 - k;
    logic [46:0] rx_in, ry_in, dsh;
    logic [14:0] qx_in, qy_in;
    logic [31:0] d_in;
    dv_side_t    side_in;

    if (k == 0) begin : g_first
      assign rx_in   = num_x_i;
      assign ry_in   = num_y_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign d_in    = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign d_in    = d_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh = 47'(d_in) << Sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k] <= d_in;
        if (rx_in >= dsh) begin
          rx_q[k] <= rx_in - dsh;
          qx_q[k] <= qx_in | (15'd1 << Sh);
        end else begin
          rx_q[k] <= rx_in;
          qx_q[k] <= qx_in;
        end
        if (ry_in >= dsh) begin
          ry_q[k] <= ry_in - dsh;
          qy_q[k] <= qy_in | (15'd1 << Sh);
        end else begin
          ry_q[k] <= ry_in;
          qy_q[k] <= qy_in;
        end
      end
    end
  end

  assign quo_x_o = qx_q[DIV_STEPS-1];
  assign quo_y_o = qy_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

FILE: design/circle_box_collision_test.sv
// Circle/circle and circle/oriented-box collision test: top level pipeline.
// Throughput: one beat per cycle while the skid entry is empty (in_stall_o low);
// the 32-stage square root and 15-stage divider set the depth.
// A two-entry output register and skid buffer decouple the pipeline from the output stall.
// Reset clears all valid bits and side structs asynchronously; other payload is not reset.
module circle_box_collision_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               first_kind_i,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic [30:0]        first_size_x_i,
  input  logic [30:0]        first_size_y_i,
  input  logic [15:0]        first_angle_i,
  input  logic               second_kind_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  input  logic [30:0]        second_size_x_i,
  input  logic [30:0]        second_size_y_i,
  input  logic [15:0]        second_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [30:0]        depth_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o
);
  import cbc_pkg::*;

  logic en;

  // Stage 0: pick circle and other shape.
  sn_side_t sn0_d, sn0_q;
  logic [15:0] ang0_d, ang0_q;
  logic signed [31:0] cx, cy, ox, oy;

  always_comb begin
    sn0_d       = '0;
    sn0_d.valid = in_valid_i;
    sn0_d.geo   = !(first_kind_i && second_kind_i);
    sn0_d.cb    = first_kind_i ^ second_kind_i;
    if (first_kind_i && !second_kind_i) begin
      cx       = second_x_i;
      cy       = second_y_i;
      ox       = first_x_i;
      oy       = first_y_i;
      sn0_d.r  = {1'b0, second_size_x_i};
      sn0_d.hx = first_size_x_i;
      sn0_d.hy = first_size_y_i;
      ang0_d   = first_angle_i;
    end else begin
      cx       = first_x_i;
      cy       = first_y_i;
      ox       = second_x_i;
      oy       = second_y_i;
      sn0_d.r  = second_kind_i ? {1'b0, first_size_x_i}
                               : 32'(first_size_x_i) + 32'(second_size_x_i);
      sn0_d.hx = second_size_x_i;
      sn0_d.hy = second_size_y_i;
      ang0_d   = second_angle_i;
    end
    sn0_d.dx = 33'(cx) - 33'(ox);
    sn0_d.dy = 33'(cy) - 33'(oy);
  end

  // Stages 1-4: sine and cosine.
  sn_side_t sn4;
  logic signed [15:0] sin4, cos4;
  logic signed [32:0] dx4, dy4;

  cbc_sine u_sine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ang_i  (ang0_q),
    .side_i (sn0_q),
    .sin_o  (sin4),
    .cos_o  (cos4),
    .side_o (sn4)
  );

  assign dx4 = sn4.dx;
  assign dy4 = sn4.dy;

  // Stage 5: project onto box axes.
  sn_side_t sn5_q;
  logic signed [15:0] sin5_q, cos5_q;
  logic signed [48:0] dxc5_q, dys5_q, dyc5_q, dxs5_q;

  // Stage 6: round and clamp to half extents.
  sn_side_t sn6_q;
  logic signed [15:0] sin6_q, cos6_q;
  logic signed [37:0] prx, pry, hxs, hys;
  logic signed [31:0] px6_d, py6_d, px6_q, py6_q;

  always_comb begin
    prx = round_q14(51'(dxc5_q) + 51'(dys5_q));
    pry = round_q14(51'(dyc5_q) - 51'(dxs5_q));
    hxs = $signed({7'b0, sn5_q.hx});
    hys = $signed({7'b0, sn5_q.hy});
    if (prx > hxs) px6_d = 32'(hxs);
    else if (prx < -hxs) px6_d = 32'(-hxs);
    else px6_d = 32'(prx);
    if (pry > hys) py6_d = 32'(hys);
    else if (pry < -hys) py6_d = 32'(-hys);
    else py6_d = 32'(pry);
  end

  // Stage 7: rotate nearest point back.
  sn_side_t sn7_q;
  logic signed [47:0] cpx7_q, spy7_q, spx7_q, cpy7_q;

  // Stage 8: vector from nearest point to circle centre.
  logic valid8_q, geo8_q;
  logic [31:0] r8_q;
  logic signed [37:0] ox8, oy8, vx8_d, vy8_d, vx8_q, vy8_q;
  logic signed [32:0] dx7, dy7;

  assign dx7 = sn7_q.dx;
  assign dy7 = sn7_q.dy;

  always_comb begin
    ox8 = round_q14(51'(cpx7_q) - 51'(spy7_q));
    oy8 = round_q14(51'(spx7_q) + 51'(cpy7_q));
    vx8_d = sn7_q.cb ? 38'(dx7) - ox8 : 38'(dx7);
    vy8_d = sn7_q.cb ? 38'(dy7) - oy8 : 38'(dy7);
  end

  // Stage 9: magnitudes and coarse range check.
  logic valid9_q, lt9_q, sx9_q, sy9_q;
  logic [31:0] r9_q, ax9_q, ay9_q;
  logic [37:0] axf, ayf;

  assign axf = vx8_q[37] ? 38'(-vx8_q) : 38'(vx8_q);
  assign ayf = vy8_q[37] ? 38'(-vy8_q) : 38'(vy8_q);

  // Stage 10: squares.
  logic valid10_q, lt10_q, sx10_q, sy10_q;
  logic [31:0] r10_q, ax10_q, ay10_q;
  logic [63:0] ax2_q, ay2_q, rr_q;

  // Stage 11: squared distance against squared radius.
  sq_side_t sq11_d, sq11_q;
  logic [64:0] dist2;
  logic [63:0] s11_q;

  assign dist2 = 65'(ax2_q) + 65'(ay2_q);

  always_comb begin
    sq11_d.valid = valid10_q;
    sq11_d.hit   = lt10_q && (dist2 < {1'b0, rr_q});
    sq11_d.sx    = sx10_q;
    sq11_d.sy    = sy10_q;
    sq11_d.ax    = ax10_q;
    sq11_d.ay    = ay10_q;
    sq11_d.r     = r10_q;
  end

  // Stages 12-43: square root.
  sq_side_t sq43;
  logic [31:0] dist43;

  cbc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .val_i  (s11_q),
    .side_i (sq11_q),
    .root_o (dist43),
    .side_o (sq43)
  );

  // Stage 44: depth and dividends.
  dv_side_t dv44_d, dv44_q;
  logic [31:0] dd44;
  logic [46:0] numx44_q, numy44_q;
  logic [31:0] dist44_q;

  assign dd44 = sq43.r - dist43;

  always_comb begin
    dv44_d.valid = sq43.valid;
    dv44_d.hit   = sq43.hit;
    dv44_d.nz    = dist43 != '0;
    dv44_d.sx    = sq43.sx;
    dv44_d.sy    = sq43.sy;
    if (!sq43.hit) dv44_d.depth = '0;
    else if (dd44[31]) dv44_d.depth = 31'h7FFF_FFFF;
    else dv44_d.depth = dd44[30:0];
  end

  // Stages 45-59: normal division.
  dv_side_t dv59;
  logic [14:0] qx59, qy59;
  logic [14:0] mx, my;
  res_t tail;

  cbc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .num_x_i (numx44_q),
    .num_y_i (numy44_q),
    .den_i   (dist44_q),
    .side_i  (dv44_q),
    .quo_x_o (qx59),
    .quo_y_o (qy59),
    .side_o  (dv59)
  );

  always_comb begin
    mx = (qx59 > 15'(Q14_ONE)) ? 15'(Q14_ONE) : qx59;
    my = (qy59 > 15'(Q14_ONE)) ? 15'(Q14_ONE) : qy59;
    tail.hit   = dv59.hit;
    tail.depth = dv59.depth;
    tail.nx    = '0;
    tail.ny    = '0;
    if (dv59.hit && dv59.nz) begin
      tail.nx = dv59.sx ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
      tail.ny = dv59.sy ? -$signed({1'b0, my}) : $signed({1'b0, my});
    end
  end

  // Pipeline valid bits and the side structs that carry them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn0_q     <= '0;
      sn5_q     <= '0;
      sn6_q     <= '0;
      sn7_q     <= '0;
      valid8_q  <= 1'b0;
      valid9_q  <= 1'b0;
      valid10_q <= 1'b0;
      sq11_q    <= '0;
      dv44_q    <= '0;
    end else if (en) begin
      sn0_q     <= sn0_d;
      sn5_q     <= sn4;
      sn6_q     <= sn5_q;
      sn7_q     <= sn6_q;
      valid8_q  <= sn7_q.valid;
      valid9_q  <= valid8_q;
      valid10_q <= valid9_q;
      sq11_q    <= sq11_d;
      dv44_q    <= dv44_d;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang0_q   <= ang0_d;
      sin5_q   <= sin4;
      cos5_q   <= cos4;
      dxc5_q   <= dx4 * cos4;
      dys5_q   <= dy4 * sin4;
      dyc5_q   <= dy4 * cos4;
      dxs5_q   <= dx4 * sin4;
      sin6_q   <= sin5_q;
      cos6_q   <= cos5_q;
      px6_q    <= px6_d;
      py6_q    <= py6_d;
      cpx7_q   <= cos6_q * px6_q;
      spy7_q   <= sin6_q * py6_q;
      spx7_q   <= sin6_q * px6_q;
      cpy7_q   <= cos6_q * py6_q;
      geo8_q   <= sn7_q.geo;
      r8_q     <= sn7_q.r;
      vx8_q    <= vx8_d;
      vy8_q    <= vy8_d;
      lt9_q    <= geo8_q && (axf < {6'b0, r8_q}) && (ayf < {6'b0, r8_q});
      sx9_q    <= vx8_q[37];
      sy9_q    <= vy8_q[37];
      r9_q     <= r8_q;
      ax9_q    <= axf[31:0];
      ay9_q    <= ayf[31:0];
      lt10_q   <= lt9_q;
      sx10_q   <= sx9_q;
      sy10_q   <= sy9_q;
      r10_q    <= r9_q;
      ax10_q   <= ax9_q;
      ay10_q   <= ay9_q;
      ax2_q    <= ax9_q * ax9_q;
      ay2_q    <= ay9_q * ay9_q;
      rr_q     <= r9_q * r9_q;
      s11_q    <= dist2[63:0];
      numx44_q <= 47'({sq43.ax, 14'd0}) + 47'(dist43[31:1]);
      numy44_q <= 47'({sq43.ay, 14'd0}) + 47'(dist43[31:1]);
      dist44_q <= dist43;
    end
  end

  // Output register with skid entry; the pipeline holds while the skid is full.
  logic out_valid_q, sk_valid_q;
  res_t out_q, sk_q;
  logic out_take, push;

  assign en         = !sk_valid_q;
  assign in_stall_o = sk_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign push       = en && dv59.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (sk_valid_q) begin
      if (out_take) begin
        sk_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !out_take) begin
        sk_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (out_take) out_q <= sk_q;
    end else if (push) begin
      if (out_valid_q && !out_take) sk_q <= tail;
      else out_q <= tail;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_q.hit;
  assign depth_o     = out_q.depth;
  assign normal_x_o  = out_q.nx;
  assign normal_y_o  = out_q.ny;

endmodule

FILE: dv/circle_box_collision_test_tb.sv
// Testbench for the circle/box collision pipeline: directed table, then random shape pairs.
`timescale 1ns / 1ps

module circle_box_collision_test_tb;

  localparam int unsigned ONE_Q14 = 16384;
  localparam logic [30:0] DEPTH_SAT = 31'h7FFF_FFFF;
  localparam int unsigned PIPE_LAT = 60;
  localparam int unsigned N_RANDOM = 1700;

  typedef enum logic {SHAPE_CIRCLE = 1'b0, SHAPE_BOX = 1'b1} shape_e;

  typedef struct packed {
    shape_e             kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        sx;
    logic [30:0]        sy;
    logic [15:0]        ang;
  } shape_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        depth;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } contact_t;

  typedef struct {
    shape_t   a;
    shape_t   b;
    logic     known;
    contact_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  shape_t first_s = '0;
  shape_t second_s = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [30:0] depth_o;
  logic signed [15:0] normal_x_o, normal_y_o;

  contact_t contact_q[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 47;

  always #5 clk_i = ~clk_i;

  circle_box_collision_test dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .first_kind_i(first_s.kind), .first_x_i(first_s.x), .first_y_i(first_s.y),
    .first_size_x_i(first_s.sx), .first_size_y_i(first_s.sy), .first_angle_i(first_s.ang),
    .second_kind_i(second_s.kind), .second_x_i(second_s.x), .second_y_i(second_s.y),
    .second_size_x_i(second_s.sx), .second_size_y_i(second_s.sy),
    .second_angle_i(second_s.ang),
    .out_valid_o, .out_stall_i, .hit_o, .depth_o, .normal_x_o, .normal_y_o
  );

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint rnd_q14(input longint v);
    longint unsigned m;
    m = (mag(v) + 8192) >> 14;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sin_q14(input logic [15:0] a);
    longint unsigned t, u, x2, p, s;
    t = a[13:0];
    u = a[14] ? ONE_Q14 - t : t;
    x2 = (u * u) >> 14;
    p = 10512 - ((x2 * 1160) >> 14);
    p = 25736 - ((x2 * p) >> 14);
    s = (u * p) >> 14;
    if (s > ONE_Q14) s = ONE_Q14;
    return a[15] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_comp(input longint v, input longint unsigned d);
    longint unsigned m;
    m = (mag(v) * ONE_Q14 + d / 2) / d;
    if (m > ONE_Q14) m = ONE_Q14;
    return v < 0 ? 16'(-m) : 16'(m);
  endfunction

  function automatic contact_t penetration(input longint vx, input longint vy,
                                           input longint unsigned r);
    contact_t c;
    longint unsigned ax, ay, rr, dx2, dy2, d, dep;
    c = '0;
    ax = mag(vx);
    ay = mag(vy);
    if (ax >= r || ay >= r) return c;
    rr = r * r;
    dx2 = ax * ax;
    dy2 = ay * ay;
    if (dy2 >= rr || dx2 >= rr - dy2) return c;
    d = int_sqrt(dx2 + dy2);
    dep = r - d;
    if (dep > DEPTH_SAT) dep = DEPTH_SAT;
    c.hit = 1'b1;
    c.depth = dep[30:0];
    if (d != 0) begin
      c.nx = unit_comp(vx, d);
      c.ny = unit_comp(vy, d);
    end
    return c;
  endfunction

  function automatic contact_t circle_vs_box(input shape_t cir, input shape_t box);
    longint s, c, dx, dy, px, py, ox, oy, hx, hy;
    s = sin_q14(box.ang);
    c = sin_q14(box.ang + 16'd16384);
    dx = longint'(cir.x) - longint'(box.x);
    dy = longint'(cir.y) - longint'(box.y);
    hx = longint'(box.sx);
    hy = longint'(box.sy);
    px = rnd_q14(dx * c + dy * s);
    py = rnd_q14(dy * c - dx * s);
    if (px > hx) px = hx;
    if (px < -hx) px = -hx;
    if (py > hy) py = hy;
    if (py < -hy) py = -hy;
    ox = rnd_q14(c * px - s * py);
    oy = rnd_q14(s * px + c * py);
    return penetration(dx - ox, dy - oy, longint'(cir.sx));
  endfunction

  function automatic contact_t collide(input shape_t a, input shape_t b);
    if (a.kind == SHAPE_CIRCLE && b.kind == SHAPE_CIRCLE)
      return penetration(longint'(a.x) - longint'(b.x), longint'(a.y) - longint'(b.y),
                         longint'(a.sx) + longint'(b.sx));
    if (a.kind == SHAPE_CIRCLE) return circle_vs_box(a, b);
    if (b.kind == SHAPE_CIRCLE) return circle_vs_box(b, a);
    return '0;
  endfunction

  function automatic shape_t mk(input shape_e k, input int x, input int y,
                                input int unsigned sx, input int unsigned sy,
                                input int unsigned ang);
    shape_t s;
    s.kind = k;
    s.x = x;
    s.y = y;
    s.sx = sx[30:0];
    s.sy = sy[30:0];
    s.ang = ang[15:0];
    return s;
  endfunction

  function automatic shape_t rand_shape(input shape_e k, input int unsigned spread);
    shape_t s;
    s.kind = k;
    s.x = $signed($urandom_range(2 * spread)) - $signed(spread);
    s.y = $signed($urandom_range(2 * spread)) - $signed(spread);
    s.sx = 31'($urandom_range(spread));
    s.sy = 31'($urandom_range(spread));
    s.ang = 16'($urandom);
    return s;
  endfunction

  // Present one beat; hold it until the block takes it.
  task automatic send_pair(input shape_t a, input shape_t b, input logic known,
                           input contact_t res);
    contact_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pred = collide(a, b);
    if (known && pred !== res)
      $display("table row disagrees with predictor: %h vs %h", res, pred);
    first_s <= a;
    second_s <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    contact_q.push_back(known ? res : pred);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    contact_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {hit_o, depth_o, normal_x_o, normal_y_o};
      if (contact_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = contact_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %0d depth %0d n (%0d,%0d) got hit %0d depth %0d n (%0d,%0d)",
                     want.hit, want.depth, want.nx, want.ny,
                     got.hit, got.depth, got.nx, got.ny);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    shape_t a, b;
    int unsigned sel;
    int unsigned spread;
    // Directed rows: expected contact typed in where obvious.
    r.known = 1; r.res = '0;
    r.a = mk(SHAPE_CIRCLE, 0, 0, 0, 0, 0); r.b = mk(SHAPE_CIRCLE, 0, 0, 0, 0, 0); rows.push_back(r);
    r.a = mk(SHAPE_BOX, 0, 0, 65536, 65536, 0); r.b = r.a; rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0);
    r.b = mk(SHAPE_CIRCLE, 32'h8000_0000, 32'h8000_0000, 1, 0, 0); rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 0, 0, 65536, 0, 0); r.b = mk(SHAPE_CIRCLE, 131072, 0, 65536, 0, 0);
    rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 0, 0, 65536, 0, 0); r.b = mk(SHAPE_CIRCLE, 0, 0, 65536, 0, 0);
    r.res = {1'b1, 31'd131072, 16'sd0, 16'sd0}; rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 65536, 0, 65536, 0, 0); r.b = mk(SHAPE_CIRCLE, 0, 0, 65536, 0, 0);
    r.res = {1'b1, 31'd65536, 16'sd16384, 16'sd0}; rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 0, 0, 31'h7FFF_FFFF, 0, 0);
    r.b = mk(SHAPE_CIRCLE, 0, 0, 31'h7FFF_FFFF, 0, 0);
    r.res = {1'b1, DEPTH_SAT, 16'sd0, 16'sd0}; rows.push_back(r);
    r.known = 0;
    r.a = mk(SHAPE_CIRCLE, 0, -65536, 65536, 0, 0); r.b = mk(SHAPE_CIRCLE, 0, 0, 65536, 0, 0);
    rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 30000, 40000, 65536, 0, 0); r.b = mk(SHAPE_CIRCLE, 0, 0, 3, 0, 0);
    rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 0, 0, 0, 31'h7FFF_FFFF, 16'hFFFF);
    r.b = mk(SHAPE_BOX, 0, 0, 65536, 65536, 0); rows.push_back(r);
    r.a = mk(SHAPE_CIRCLE, 100000, 0, 65536, 0, 0);
    r.b = mk(SHAPE_BOX, 0, 0, 65536, 65536, 16'h2000); rows.push_back(r);
    r.a = mk(SHAPE_BOX, 0, 0, 65536, 32768, 16'h4000);
    r.b = mk(SHAPE_CIRCLE, 0, 90000, 65536, 0, 0); rows.push_back(r);
    r.a = mk(SHAPE_BOX, 5, 5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h8000);
    r.b = mk(SHAPE_CIRCLE, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0); rows.push_back(r);
    r.a = mk(SHAPE_BOX, 0, 0, 0, 0, 16'hC000);
    r.b = mk(SHAPE_CIRCLE, 70000, -70000, 200000, 0, 0); rows.push_back(r);
    r.a = mk(SHAPE_BOX, -65536, 0, 65536, 65536, 16'hFFFF);
    r.b = mk(SHAPE_CIRCLE, 0, 0, 1000, 0, 0); rows.push_back(r);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_pair(rows[i].a, rows[i].b, rows[i].known, rows[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 11;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sel = $urandom_range(9);
      // Mostly near-overlapping pairs; a few fully random words.
      spread = (sel == 0) ? 32'h7FFF_FFFF : (32'd1 << $urandom_range(24, 8));
      a = rand_shape(shape_e'($urandom_range(1)), spread);
      b = rand_shape(shape_e'($urandom_range(3) == 0), spread);
      if (sel == 0) begin
        a.x = $urandom; a.y = $urandom; b.x = $urandom; b.y = $urandom;
        a.sx = 31'($urandom); a.sy = 31'($urandom); b.sx = 31'($urandom); b.sy = 31'($urandom);
      end else if (sel == 1) begin
        b.x = a.x; b.y = a.y;
      end
      if ($urandom_range(1)) send_pair(a, b, 1'b0, '0);
      else send_pair(b, a, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
